[hw/rtl/twcc_feedback_status_decoder_core_macros.svh]
// Assertion helpers for the feedback status decoder.
`ifndef TWCC_FEEDBACK_STATUS_DECODER_CORE_MACROS_SVH
`define TWCC_FEEDBACK_STATUS_DECODER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

`define TWCC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define TWCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define TWCC_ASSERT_SAME(label, clk, rst_n, ante, cons)

`define TWCC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[hw/rtl/twcc_pkg.sv]
package twcc_pkg;

    localparam logic [4:0] POS_BASE_HI    = 5'd12;
    localparam logic [4:0] POS_BASE_LO    = 5'd13;
    localparam logic [4:0] POS_TOTAL_HI   = 5'd14;
    localparam logic [4:0] POS_TOTAL_LO   = 5'd15;
    localparam logic [4:0] POS_REFTIME_HI = 5'd16;
    localparam logic [4:0] POS_REFTIME_MD = 5'd17;
    localparam logic [4:0] POS_REFTIME_LO = 5'd18;
    localparam logic [4:0] POS_LAST_HDR   = 5'd19;
    localparam logic [4:0] CHUNK_START    = 5'd20;

    localparam logic [3:0] SYM_1BIT = 4'd14;
    localparam logic [3:0] SYM_2BIT = 4'd7;

    localparam int OUT_DATA_W = 88;

    typedef struct packed {
        logic [15:0] add_count;
        logic [15:0] lost_count;
    } t_chunk_cnt;

    typedef struct packed {
        logic [15:0] base_seq;
        logic [15:0] status_total;
        logic [23:0] ref_time;
        logic [15:0] expected_count;
        logic [15:0] lost_count;
        logic        loss_valid;
    } t_result;

endpackage

[hw/rtl/twcc_feedback_status_decoder_core.sv]
// Feedback status decoder: takes one packet byte per cycle on the slave stream, tlast on the
// final byte, and on that byte emits one summary item (header fields, expected and lost
// status counts, loss flag) if the packet held at least 20 bytes; shorter packets emit
// nothing. Throughput is one byte per cycle, set by the combinational chunk decode between
// the input register and the result register, which the final byte passes through in that
// order on its way to the result. Only a final byte waits, and only while the previous
// result still sits unread in the output register.
`include "twcc_feedback_status_decoder_core_macros.svh"

module twcc_feedback_status_decoder_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // data_byte[7:0]
    input  logic [7:0]                        i_s_axis_tdata,
    input  logic                              i_s_axis_tlast,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // base_seq[15:0], status_total[31:16], ref_time[55:32],
    // expected_count[71:56], lost_count[87:72]
    output logic [twcc_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata,
    // loss_valid[0]
    output logic                              o_m_axis_tuser
);

    logic                               res_valid;
    twcc_pkg::t_result                  res;
    logic                               res_ready;
    logic                               r_out_valid;
    logic [twcc_pkg::OUT_DATA_W-1:0]    r_out_data;
    logic                               r_out_user;
    logic [15:0]                        out_total;
    logic [15:0]                        out_expected;
    logic [15:0]                        out_lost;
    logic                               out_stall;

    assign res_ready = !r_out_valid || i_m_axis_tready;

    twcc_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .i_data      (i_s_axis_tdata),
        .i_last      (i_s_axis_tlast),
        .o_ready     (o_s_axis_tready),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out_data <= {res.lost_count, res.expected_count, res.ref_time,
                           res.status_total, res.base_seq};
            r_out_user <= res.loss_valid;
        end
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

    assign out_total    = r_out_data[31:16];
    assign out_expected = r_out_data[71:56];
    assign out_lost     = r_out_data[87:72];
    assign out_stall    = r_out_valid && !i_m_axis_tready;

    `TWCC_ASSERT_SAME(a_lost_le_exp, i_clk, i_rst_n, r_out_valid, out_lost <= out_expected)
    `TWCC_ASSERT_SAME(a_exp_le_total, i_clk, i_rst_n, r_out_valid, out_expected <= out_total)
    `TWCC_ASSERT_SAME(a_result_needs_slot, i_clk, i_rst_n, res_valid, res_ready)
    `TWCC_ASSERT_NEXT(a_out_held, i_clk, i_rst_n, out_stall, r_out_valid && $stable(r_out_data))

endmodule

[hw/rtl/twcc_chunk_dec.sv]
module twcc_chunk_dec (
    input  logic [15:0]           i_chunk,
    input  logic [15:0]           i_remaining,
    output twcc_pkg::t_chunk_cnt  o_cnt
);

    logic [15:0] run_len;
    logic [15:0] run_take;
    logic [3:0]  n_sym;
    logic [3:0]  take;
    logic [13:0] zero_sym;
    logic [13:0] take_mask;

    always_comb begin
        run_len  = {3'b000, i_chunk[12:0]};
        run_take = (run_len < i_remaining) ? run_len : i_remaining;

        n_sym = i_chunk[14] ? twcc_pkg::SYM_2BIT : twcc_pkg::SYM_1BIT;
        take  = (i_remaining < {12'd0, n_sym}) ? i_remaining[3:0] : n_sym;

        for (int i = 0; i < 14; i++) begin
            zero_sym[i]  = 1'b0;
            take_mask[i] = (4'(i) < take);
        end
        if (i_chunk[14]) begin
            for (int i = 0; i < 7; i++) begin
                zero_sym[i] = (i_chunk[12 - 2 * i +: 2] == 2'b00);
            end
        end else begin
            for (int i = 0; i < 14; i++) begin
                zero_sym[i] = ~i_chunk[13 - i];
            end
        end

        if (!i_chunk[15]) begin
            o_cnt.add_count  = run_take;
            o_cnt.lost_count = (i_chunk[14:13] == 2'b00) ? run_take : 16'd0;
        end else begin
            o_cnt.add_count  = {12'd0, take};
            o_cnt.lost_count = {12'd0, 4'($countones(zero_sym & take_mask))};
        end
    end

endmodule

[hw/rtl/twcc_parser.sv]
module twcc_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [7:0]         i_data,
    input  logic               i_last,
    output logic               o_ready,
    output logic               o_res_valid,
    output twcc_pkg::t_result  o_res,
    input  logic               i_res_ready
);

    logic        r_in_valid;
    logic [7:0]  r_in_data;
    logic        r_in_last;

    logic [4:0]  r_pos,        n_pos;
    logic        r_phase,      n_phase;
    logic [7:0]  r_chunk_high, n_chunk_high;
    logic [15:0] r_base,       n_base;
    logic [15:0] r_total,      n_total;
    logic [23:0] r_reftime,    n_reftime;
    logic [15:0] r_parsed,     n_parsed;
    logic [15:0] r_lost,       n_lost;

    logic                 go;
    twcc_pkg::t_chunk_cnt cnt;

    assign go      = r_in_valid && (!r_in_last || i_res_ready);
    assign o_ready = !r_in_valid || go;

    twcc_chunk_dec u_chunk_dec (
        .i_chunk     ({r_chunk_high, r_in_data}),
        .i_remaining (r_total - r_parsed),
        .o_cnt       (cnt)
    );

    always_comb begin
        n_pos        = r_pos;
        n_phase      = r_phase;
        n_chunk_high = r_chunk_high;
        n_base       = r_base;
        n_total      = r_total;
        n_reftime    = r_reftime;
        n_parsed     = r_parsed;
        n_lost       = r_lost;

        case (r_pos)
            twcc_pkg::POS_BASE_HI:    n_base    = {r_in_data, r_base[7:0]};
            twcc_pkg::POS_BASE_LO:    n_base    = {r_base[15:8], r_in_data};
            twcc_pkg::POS_TOTAL_HI:   n_total   = {r_in_data, r_total[7:0]};
            twcc_pkg::POS_TOTAL_LO:   n_total   = {r_total[15:8], r_in_data};
            twcc_pkg::POS_REFTIME_HI: n_reftime = {r_in_data, r_reftime[15:0]};
            twcc_pkg::POS_REFTIME_MD: n_reftime = {r_reftime[23:16], r_in_data,
                                                   r_reftime[7:0]};
            twcc_pkg::POS_REFTIME_LO: n_reftime = {r_reftime[23:8], r_in_data};
            default: ;
        endcase

        if (r_pos >= twcc_pkg::CHUNK_START) begin
            if (!r_phase) begin
                n_chunk_high = r_in_data;
                n_phase      = 1'b1;
            end else begin
                n_parsed = r_parsed + cnt.add_count;
                n_lost   = r_lost + cnt.lost_count;
                n_phase  = 1'b0;
            end
        end else begin
            n_pos = r_pos + 5'd1;
        end

        o_res_valid          = go && r_in_last && (r_pos >= twcc_pkg::POS_LAST_HDR);
        o_res.base_seq       = n_base;
        o_res.status_total   = n_total;
        o_res.ref_time       = n_reftime;
        o_res.expected_count = n_parsed;
        o_res.lost_count     = n_lost;
        o_res.loss_valid     = (n_parsed != 16'd0);
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_in_data <= i_data;
            r_in_last <= i_last;
        end
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_pos        <= 5'd0;
            r_phase      <= 1'b0;
            r_chunk_high <= 8'd0;
            r_base       <= 16'd0;
            r_total      <= 16'd0;
            r_reftime    <= 24'd0;
            r_parsed     <= 16'd0;
            r_lost       <= 16'd0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (go && r_in_last) begin
                r_pos        <= 5'd0;
                r_phase      <= 1'b0;
                r_chunk_high <= 8'd0;
                r_base       <= 16'd0;
                r_total      <= 16'd0;
                r_reftime    <= 24'd0;
                r_parsed     <= 16'd0;
                r_lost       <= 16'd0;
            end else if (go) begin
                r_pos        <= n_pos;
                r_phase      <= n_phase;
                r_chunk_high <= n_chunk_high;
                r_base       <= n_base;
                r_total      <= n_total;
                r_reftime    <= n_reftime;
                r_parsed     <= n_parsed;
                r_lost       <= n_lost;
            end
        end
    end

endmodule

[dv/tb_twcc_feedback_status_decoder_core.sv]
`timescale 1ns / 1ps

module tb_twcc_feedback_status_decoder_core;

    localparam int BYTE_TARGET = 1650;
    localparam int DRAIN_CYCLES = 8;
    localparam int RX_HOLD_CYCLES = 800;
    localparam int DIR_ROWS = 16;

    typedef struct packed {
        logic [4:0]  short_len;   // 0: full header, else byte count of a short packet
        logic [15:0] base;
        logic [15:0] total;
        logic [23:0] reftime;
        logic [2:0]  n_chunks;
        logic [63:0] chunks;      // first chunk in the top bits
        logic        odd_tail;
        logic        typed;
        logic [15:0] exp_cnt;
        logic [15:0] lost_cnt;
    } t_dir_row;

    localparam t_dir_row DIR_TAB [DIR_ROWS] = '{
        '{5'd1,  16'h0000, 16'h0000, 24'h000000, 3'd0, 64'h0, 1'b0, 1'b0, 16'd0, 16'd0},
        '{5'd19, 16'h0000, 16'h0000, 24'h000000, 3'd0, 64'h0, 1'b0, 1'b0, 16'd0, 16'd0},
        '{5'd0,  16'h0000, 16'h0000, 24'h000000, 3'd0, 64'h0, 1'b0, 1'b1, 16'd0, 16'd0},
        '{5'd0,  16'hffff, 16'hffff, 24'hffffff, 3'd1, 64'h3fff_0000_0000_0000,
          1'b0, 1'b1, 16'd8191, 16'd0},
        '{5'd0,  16'h1234, 16'h0000, 24'habcdef, 3'd1, 64'h2005_0000_0000_0000,
          1'b0, 1'b1, 16'd0, 16'd0},
        '{5'd0,  16'h8001, 16'd10, 24'h800001, 3'd2, 64'h0005_6003_0000_0000,
          1'b0, 1'b1, 16'd8, 16'd5},
        '{5'd0,  16'h00ff, 16'd4, 24'h00ff00, 3'd1, 64'h0064_0000_0000_0000,
          1'b0, 1'b1, 16'd4, 16'd4},
        '{5'd0,  16'h5555, 16'd14, 24'h555555, 3'd1, 64'ha0f0_0000_0000_0000,
          1'b0, 1'b1, 16'd14, 16'd9},
        '{5'd0,  16'haaaa, 16'd7, 24'haaaaaa, 3'd1, 64'hd8e4_0000_0000_0000,
          1'b0, 1'b1, 16'd7, 16'd2},
        '{5'd0,  16'h0102, 16'd3, 24'h030405, 3'd2, 64'hbfff_0010_0000_0000,
          1'b0, 1'b1, 16'd3, 16'd0},
        '{5'd0,  16'hfffe, 16'd20, 24'h7fffff, 3'd1, 64'h0002_0000_0000_0000,
          1'b1, 1'b1, 16'd2, 16'd2},
        '{5'd0,  16'h0001, 16'd5, 24'h000001, 3'd1, 64'h2000_0000_0000_0000,
          1'b0, 1'b1, 16'd0, 16'd0},
        '{5'd0,  16'h7fff, 16'd9, 24'hffff00, 3'd2, 64'h4003_8000_0000_0000,
          1'b0, 1'b1, 16'd9, 16'd6},
        '{5'd0,  16'hc3a5, 16'd40, 24'h123456, 3'd4, 64'h9f0f_e4e4_200a_0007,
          1'b1, 1'b0, 16'd0, 16'd0},
        '{5'd0,  16'h0000, 16'hffff, 24'h000000, 3'd4, 64'h1fff_7fff_5fff_ffff,
          1'b0, 1'b0, 16'd0, 16'd0},
        '{5'd12, 16'h0000, 16'h0000, 24'h000000, 3'd0, 64'h0, 1'b0, 1'b0, 16'd0, 16'd0}
    };

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_s_axis_tvalid;
    logic                            o_s_axis_tready;
    logic [7:0]                      i_s_axis_tdata;
    logic                            i_s_axis_tlast;
    logic                            o_m_axis_tvalid;
    logic                            i_m_axis_tready;
    logic [twcc_pkg::OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                            o_m_axis_tuser;

    // decoder state of the predictor
    logic [4:0]  fb_pos = '0;
    logic        fb_phase = 1'b0;
    logic [7:0]  fb_hi = '0;
    logic [15:0] fb_base = '0;
    logic [15:0] fb_total = '0;
    logic [23:0] fb_reftime = '0;
    logic [15:0] fb_parsed = '0;
    logic [15:0] fb_lost = '0;
    logic [15:0] fb_rcvd = '0;

    twcc_pkg::t_result summary_q[$];
    logic [7:0]        pkt_bytes[$];
    int                err_cnt = 0;
    int                bytes_sent = 0;
    int                rx_hold_req = 0;
    bit                rx_lazy = 1'b0;
    bit                tx_lazy = 1'b0;
    twcc_pkg::t_result seen;
    twcc_pkg::t_result want;

    twcc_feedback_status_decoder_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tlast (i_s_axis_tlast),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tuser (o_m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        err_cnt++;
    endtask

    task automatic check_field(input string name, input logic [23:0] got,
                               input logic [23:0] exp_val);
        if (got !== exp_val) begin
            report_mismatch($sformatf("%s got %h want %h", name, got, exp_val));
        end
    endtask

    task automatic append_byte(input logic [7:0] b);
        pkt_bytes = {pkt_bytes, b};
    endtask

    task automatic tally_status(input logic received, input logic [15:0] n);
        if (received) begin
            fb_rcvd = fb_rcvd + n;
        end else begin
            fb_lost = fb_lost + n;
        end
        fb_parsed = fb_parsed + n;
    endtask

    // advance the predictor by one accepted item
    task automatic decode_feedback_byte(input logic [7:0] b, input logic lst);
        logic [4:0]        pos;
        logic [15:0]       chunk;
        logic [15:0]       room;
        logic [15:0]       run;
        logic [1:0]        sym;
        int                n_sym;
        int                i;
        twcc_pkg::t_result sum;
        pos = fb_pos;
        case (pos)
            twcc_pkg::POS_BASE_HI:    fb_base[15:8] = b;
            twcc_pkg::POS_BASE_LO:    fb_base[7:0] = b;
            twcc_pkg::POS_TOTAL_HI:   fb_total[15:8] = b;
            twcc_pkg::POS_TOTAL_LO:   fb_total[7:0] = b;
            twcc_pkg::POS_REFTIME_HI: fb_reftime[23:16] = b;
            twcc_pkg::POS_REFTIME_MD: fb_reftime[15:8] = b;
            twcc_pkg::POS_REFTIME_LO: fb_reftime[7:0] = b;
            default: ;
        endcase
        if (pos >= twcc_pkg::CHUNK_START) begin
            if (!fb_phase) begin
                fb_hi = b;
                fb_phase = 1'b1;
            end else begin
                fb_phase = 1'b0;
                chunk = {fb_hi, b};
                if (fb_parsed < fb_total) begin
                    if (!chunk[15]) begin
                        room = fb_total - fb_parsed;
                        run = {3'b000, chunk[12:0]};
                        tally_status(chunk[14:13] != 2'b00, (run < room) ? run : room);
                    end else begin
                        n_sym = chunk[14] ? int'(twcc_pkg::SYM_2BIT)
                                          : int'(twcc_pkg::SYM_1BIT);
                        for (i = 0; i < n_sym && fb_parsed < fb_total; i++) begin
                            if (chunk[14]) begin
                                sym = chunk[12 - 2 * i +: 2];
                            end else begin
                                sym = {1'b0, chunk[13 - i]};
                            end
                            tally_status(sym != 2'b00, 16'd1);
                        end
                    end
                end
            end
        end else begin
            fb_pos = pos + 5'd1;
        end
        if (lst) begin
            if (pos >= twcc_pkg::POS_LAST_HDR) begin
                sum.base_seq = fb_base;
                sum.status_total = fb_total;
                sum.ref_time = fb_reftime;
                sum.expected_count = fb_rcvd + fb_lost;
                sum.lost_count = fb_lost;
                sum.loss_valid = (fb_rcvd + fb_lost) != 16'd0;
                summary_q = {summary_q, sum};
            end
            fb_pos = '0;
            fb_phase = 1'b0;
            fb_hi = '0;
            fb_base = '0;
            fb_total = '0;
            fb_reftime = '0;
            fb_parsed = '0;
            fb_lost = '0;
            fb_rcvd = '0;
        end
    endtask

    task automatic push_byte(input logic [7:0] b, input logic lst);
        int gap;
        gap = tx_lazy ? $urandom_range(0, 17) : 0;
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= b;
        i_s_axis_tlast <= lst;
        do @(posedge i_clk); while (!o_s_axis_tready);
        bytes_sent++;
        decode_feedback_byte(b, lst);
    endtask

    task automatic send_packet(input bit allow_gaps);
        int i;
        tx_lazy = allow_gaps && ($urandom_range(0, 3) != 0);
        for (i = 0; i < pkt_bytes.size(); i++) begin
            push_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
        end
    endtask

    task automatic put_header(input logic [15:0] base, input logic [15:0] total,
                              input logic [23:0] reftime);
        logic [31:0] r;
        int          i;
        for (i = 0; i < 12; i++) begin
            r = $urandom;
            append_byte(r[7:0]);
        end
        append_byte(base[15:8]);
        append_byte(base[7:0]);
        append_byte(total[15:8]);
        append_byte(total[7:0]);
        append_byte(reftime[23:16]);
        append_byte(reftime[15:8]);
        append_byte(reftime[7:0]);
        r = $urandom;
        append_byte(r[7:0]);
    endtask

    task automatic build_random_packet();
        logic [31:0] r;
        logic [31:0] hdr;
        logic [15:0] total;
        logic [15:0] chunk;
        int          kind;
        int          len;
        int          n_chunk;
        int          i;
        pkt_bytes.delete();
        kind = $urandom_range(0, 15);
        if (kind < 2) begin
            len = (kind == 0) ? $urandom_range(1, 19) : $urandom_range(20, 40);
            for (i = 0; i < len; i++) begin
                r = $urandom;
                append_byte(r[7:0]);
            end
        end else begin
            r = $urandom;
            case ($urandom_range(0, 5))
                0:       total = 16'd0;
                1:       total = r[15:0];
                2, 3:    total = 16'($urandom_range(1, 40));
                default: total = 16'($urandom_range(1, 300));
            endcase
            r = $urandom;
            hdr = $urandom;
            put_header(r[31:16], total, hdr[23:0]);
            n_chunk = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 24)
                                                  : $urandom_range(0, 6);
            for (i = 0; i < n_chunk; i++) begin
                r = $urandom;
                case ($urandom_range(0, 3))
                    0:       chunk = {1'b0, r[14:13], 13'($urandom_range(0, 30))};
                    1:       chunk = {1'b0, r[14:0]};
                    2:       chunk = {2'b10, r[13:0]};
                    default: chunk = {2'b11, r[13:0]};
                endcase
                append_byte(chunk[15:8]);
                append_byte(chunk[7:0]);
            end
            if ($urandom_range(0, 3) == 0) begin
                r = $urandom;
                append_byte(r[7:0]);
            end
        end
    endtask

    task automatic drain_summaries();
        i_s_axis_tvalid <= 1'b0;
        while (summary_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            seen.base_seq = o_m_axis_tdata[15:0];
            seen.status_total = o_m_axis_tdata[31:16];
            seen.ref_time = o_m_axis_tdata[55:32];
            seen.expected_count = o_m_axis_tdata[71:56];
            seen.lost_count = o_m_axis_tdata[87:72];
            seen.loss_valid = o_m_axis_tuser;
            if (summary_q.size() == 0) begin
                report_mismatch($sformatf("summary with none pending: %h", o_m_axis_tdata));
            end else begin
                want = summary_q[0];
                summary_q.delete(0);
                check_field("base_seq", 24'(seen.base_seq), 24'(want.base_seq));
                check_field("status_total", 24'(seen.status_total), 24'(want.status_total));
                check_field("ref_time", seen.ref_time, want.ref_time);
                check_field("expected_count", 24'(seen.expected_count),
                            24'(want.expected_count));
                check_field("lost_count", 24'(seen.lost_count), 24'(want.lost_count));
                check_field("loss_valid", 24'(seen.loss_valid), 24'(want.loss_valid));
            end
        end
    end

    initial begin : rx_side
        int gap;
        int hold;
        i_m_axis_tready = 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (rx_hold_req > 0) begin
                hold = rx_hold_req;
                rx_hold_req = 0;
                i_m_axis_tready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            if ($urandom_range(0, 7) == 0) begin
                rx_lazy = !rx_lazy;
            end
            gap = rx_lazy ? $urandom_range(0, 17) : 0;
            if (gap > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid && rx_hold_req == 0);
        end
    end

    initial begin : watchdog
        #5_000_000;
        $display("twcc_feedback_status_decoder_core test failed");
        $finish;
    end

    initial begin : tx_side
        t_dir_row          row;
        twcc_pkg::t_result typed;
        logic [31:0]       r;
        logic [15:0]       chunk;
        int                n;
        int                c;
        int                k;
        bit                hold_done;
        hold_done = 1'b0;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_s_axis_tlast = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (n = 0; n < DIR_ROWS; n++) begin
            row = DIR_TAB[n];
            pkt_bytes.delete();
            if (row.short_len != 0) begin
                for (k = 0; k < row.short_len; k++) begin
                    r = $urandom;
                    append_byte(r[7:0]);
                end
            end else begin
                put_header(row.base, row.total, row.reftime);
                for (c = 0; c < row.n_chunks; c++) begin
                    chunk = row.chunks[63 - 16 * c -: 16];
                    append_byte(chunk[15:8]);
                    append_byte(chunk[7:0]);
                end
                if (row.odd_tail) begin
                    r = $urandom;
                    append_byte(r[7:0]);
                end
            end
            send_packet(1'b1);
            if (row.typed) begin
                typed.base_seq = row.base;
                typed.status_total = row.total;
                typed.ref_time = row.reftime;
                typed.expected_count = row.exp_cnt;
                typed.lost_count = row.lost_cnt;
                typed.loss_valid = row.exp_cnt != 16'd0;
                summary_q[summary_q.size() - 1] = typed;
            end
        end
        drain_summaries();

        while (bytes_sent < BYTE_TARGET) begin
            if (!hold_done && bytes_sent > BYTE_TARGET / 3) begin
                hold_done = 1'b1;
                // hold the result side while packets keep coming at full rate
                rx_hold_req = RX_HOLD_CYCLES;
                for (k = 0; k < 4; k++) begin
                    build_random_packet();
                    send_packet(1'b0);
                end
                drain_summaries();
            end
            build_random_packet();
            send_packet(1'b1);
        end
        drain_summaries();

        if (err_cnt == 0) begin
            $display("twcc_feedback_status_decoder_core test passed");
        end else begin
            $display("twcc_feedback_status_decoder_core test failed");
        end
        $finish;
    end

endmodule
